FILE: src/eisp_pkg.sv
package eisp_pkg;

    localparam int CODE_W            = 24;
    localparam int CHAN_W            = 5;
    localparam int CHIP_W            = 2;
    localparam int PIN_W             = 8;
    localparam int SETTLE_W          = 4;
    localparam int WINDOW_W          = 6;
    localparam int CFG_INDEX_W       = 1;
    localparam int CFG_DATA_W        = 6;

    localparam int CHANNEL_COUNT_DEF = 32;
    localparam int CHANNELS_PER_CHIP = 8;
    localparam int PIN_IDX_W         = $clog2(CHANNELS_PER_CHIP);
    localparam int MAX_WINDOW        = 32;
    localparam int SAMPLE_W          = $clog2(MAX_WINDOW);
    localparam int QUEUE_DEPTH       = 2;

    localparam logic [SETTLE_W-1:0] SETTLE_RESET = SETTLE_W'(10);
    localparam logic [WINDOW_W-1:0] WINDOW_RESET = WINDOW_W'(MAX_WINDOW);

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_SETTLE_COUNT  = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_LENGTH = 1'd1;

    typedef struct packed {
        logic signed [CODE_W-1:0] raw_code;
        logic                     restart;
    } sample_t;

    typedef struct packed {
        logic [CHAN_W-1:0] channel;
        logic [CHIP_W-1:0] chip;
        logic [CODE_W-1:0] pk_pk;
        logic [CHIP_W-1:0] next_chip;
        logic [PIN_W-1:0]  next_pin_mask;
        logic              sweep_done;
    } result_t;

    // one kept sample handed from the front to the back
    typedef struct packed {
        logic signed [CODE_W-1:0] raw_code;
        logic                     first;
        logic                     win_end;
        logic                     last_chan;
        logic [CHAN_W-1:0]        channel;
    } op_t;

endpackage

FILE: src/electrode_impedance_sweep_pkpk_core.sv
// channel   | direction | handshake                  | beat
// ----------+-----------+----------------------------+------------------------------
// sample    | in        | sample_valid/sample_stall  | raw_code, restart
// result    | out       | result_valid/result_stall  | channel, chip, pk_pk, next_*
// cfg       | in        | cfg_we, cfg_index          | cfg_data, write only
//
// one sample beat per cycle sustained while the queue has room; result_valid rises after
// the window-closing beat passes the queue entry and then the back result register
// the two-entry queue between front and back sets the slack against result_stall
// reset clears counters, channel, queue and output valid; settle 10, window 32
// sample_stall rises only when the queue is full behind a stalled result
module electrode_impedance_sweep_pkpk_core #(
    parameter int CHANNEL_COUNT = eisp_pkg::CHANNEL_COUNT_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 sample_valid,
    output logic                                 sample_stall,
    input  eisp_pkg::sample_t                    sample,
    output logic                                 result_valid,
    input  logic                                 result_stall,
    output eisp_pkg::result_t                    result,
    input  logic                                 cfg_we,
    input  logic [eisp_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [eisp_pkg::CFG_DATA_W-1:0]      cfg_data
);

    logic [eisp_pkg::SETTLE_W-1:0] settle_count_reg;
    logic [eisp_pkg::WINDOW_W-1:0] window_length_reg;

    logic          accept;
    logic          push;
    logic          pop;
    logic          q_full;
    logic          q_valid;
    eisp_pkg::op_t push_op;
    eisp_pkg::op_t head_op;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            settle_count_reg  <= eisp_pkg::SETTLE_RESET;
            window_length_reg <= eisp_pkg::WINDOW_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                eisp_pkg::REG_SETTLE_COUNT:
                begin
                    settle_count_reg <= cfg_data[eisp_pkg::SETTLE_W-1:0];
                end
                eisp_pkg::REG_WINDOW_LENGTH:
                begin
                    window_length_reg <= cfg_data[eisp_pkg::WINDOW_W-1:0];
                end
                default:
                begin
                    settle_count_reg <= settle_count_reg;
                end
            endcase
        end
    end

    // front takes a beat whenever the queue has room
    assign sample_stall = q_full;
    assign accept       = sample_valid && !q_full;

    // front: restart, idle and settling decisions, window and channel counting
    eisp_front #(
        .CHANNEL_COUNT (CHANNEL_COUNT)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .sample        (sample),
        .settle_count  (settle_count_reg),
        .window_length (window_length_reg),
        .push          (push),
        .op            (push_op)
    );

    // short queue of kept samples
    eisp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_op   (push_op),
        .pop       (pop),
        .full      (q_full),
        .not_empty (q_valid),
        .head      (head_op)
    );

    // back: running min/max and the result register
    eisp_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .op_valid     (q_valid),
        .op           (head_op),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    // last channel turns every lead-off current off
    a_done_currents_off: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.sweep_done |->
            result.next_pin_mask == '0 && result.next_chip == '0)
        else $error("sweep done with current still selected");

    // every other result selects exactly one pin
    a_next_pin_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.sweep_done |-> $onehot(result.next_pin_mask))
        else $error("next pin mask not one-hot");

    // chip field follows the channel number
    a_chip_matches: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |->
            result.chip == result.channel[eisp_pkg::CHAN_W-1:eisp_pkg::PIN_IDX_W])
        else $error("chip does not match channel");

    // the input side only stalls while the queue is blocked behind the output
    a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        sample_stall |-> q_valid)
        else $error("input stalled with an empty queue");

endmodule

FILE: src/eisp_front.sv
module eisp_front #(
    parameter int CHANNEL_COUNT = eisp_pkg::CHANNEL_COUNT_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              accept,
    input  eisp_pkg::sample_t                 sample,
    input  logic [eisp_pkg::SETTLE_W-1:0]     settle_count,
    input  logic [eisp_pkg::WINDOW_W-1:0]     window_length,
    output logic                              push,
    output eisp_pkg::op_t                     op
);

    logic [eisp_pkg::CHAN_W-1:0]   chan_reg, chan_next;
    logic [eisp_pkg::SETTLE_W-1:0] settle_reg, settle_next;
    logic [eisp_pkg::SAMPLE_W-1:0] sample_reg, sample_next;
    logic                          idle_reg, idle_next;

    logic [eisp_pkg::WINDOW_W-1:0] win;
    logic [eisp_pkg::WINDOW_W-1:0] sample_inc;
    logic [eisp_pkg::CHAN_W:0]     chan_inc;
    logic                          win_end;
    logic                          last_chan;
    logic                          keep;

    // window length clamped to 1..32
    always_comb
    begin
        if (window_length == '0)
        begin
            win = eisp_pkg::WINDOW_W'(1);
        end
        else if (window_length > eisp_pkg::WINDOW_W'(eisp_pkg::MAX_WINDOW))
        begin
            win = eisp_pkg::WINDOW_W'(eisp_pkg::MAX_WINDOW);
        end
        else
        begin
            win = window_length;
        end
    end

    assign sample_inc = {1'b0, sample_reg} + eisp_pkg::WINDOW_W'(1);
    assign win_end    = sample_inc >= win;
    assign chan_inc   = {1'b0, chan_reg} + (eisp_pkg::CHAN_W+1)'(1);
    assign last_chan  = chan_inc >= (eisp_pkg::CHAN_W+1)'(CHANNEL_COUNT);
    assign keep       = !sample.restart && !idle_reg && !(settle_reg < settle_count);
    assign push       = accept && keep;

    assign op.raw_code  = sample.raw_code;
    assign op.first     = sample_reg == '0;
    assign op.win_end   = win_end;
    assign op.last_chan = last_chan;
    assign op.channel   = chan_reg;

    always_comb
    begin
        chan_next   = chan_reg;
        settle_next = settle_reg;
        sample_next = sample_reg;
        idle_next   = idle_reg;
        if (accept)
        begin
            if (sample.restart)
            begin
                chan_next   = '0;
                settle_next = '0;
                sample_next = '0;
                idle_next   = 1'b0;
            end
            else if (!idle_reg)
            begin
                if (settle_reg < settle_count)
                begin
                    settle_next = settle_reg + eisp_pkg::SETTLE_W'(1);
                end
                else if (win_end)
                begin
                    settle_next = '0;
                    sample_next = '0;
                    if (last_chan)
                    begin
                        idle_next = 1'b1;
                        chan_next = '0;
                    end
                    else
                    begin
                        chan_next = chan_inc[eisp_pkg::CHAN_W-1:0];
                    end
                end
                else
                begin
                    sample_next = sample_inc[eisp_pkg::SAMPLE_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chan_reg   <= '0;
            settle_reg <= '0;
            sample_reg <= '0;
            idle_reg   <= 1'b0;
        end
        else
        begin
            chan_reg   <= chan_next;
            settle_reg <= settle_next;
            sample_reg <= sample_next;
            idle_reg   <= idle_next;
        end
    end

endmodule

FILE: src/eisp_queue.sv
module eisp_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  eisp_pkg::op_t  push_op,
    input  logic           pop,
    output logic           full,
    output logic           not_empty,
    output eisp_pkg::op_t  head
);

    localparam int PTR_W = $clog2(eisp_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(eisp_pkg::QUEUE_DEPTH + 1);

    eisp_pkg::op_t    entry_reg [eisp_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(eisp_pkg::QUEUE_DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + PTR_W'(1);
        end
        return r;
    endfunction

    assign full      = count_reg == CNT_W'(eisp_pkg::QUEUE_DEPTH);
    assign not_empty = count_reg != '0;
    assign head      = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop  ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: src/eisp_back.sv
module eisp_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               op_valid,
    input  eisp_pkg::op_t      op,
    output logic               pop,
    output logic               result_valid,
    input  logic               result_stall,
    output eisp_pkg::result_t  result
);

    logic signed [eisp_pkg::CODE_W-1:0] max_reg, max_next;
    logic signed [eisp_pkg::CODE_W-1:0] min_reg, min_next;
    logic                               valid_reg, valid_next;
    eisp_pkg::result_t                  result_reg, result_next;

    logic                               slot_free;
    logic [eisp_pkg::CHAN_W-1:0]        nxt;

    assign slot_free = !valid_reg || !result_stall;
    // a window-closing sample waits until the output slot is free
    assign pop       = op_valid && (!op.win_end || slot_free);
    assign nxt       = op.channel + eisp_pkg::CHAN_W'(1);

    always_comb
    begin
        max_next    = max_reg;
        min_next    = min_reg;
        result_next = result_reg;
        valid_next  = valid_reg && result_stall;
        if (pop)
        begin
            if (op.first)
            begin
                max_next = op.raw_code;
                min_next = op.raw_code;
            end
            else
            begin
                if (op.raw_code > max_reg)
                begin
                    max_next = op.raw_code;
                end
                if (op.raw_code < min_reg)
                begin
                    min_next = op.raw_code;
                end
            end
            if (op.win_end)
            begin
                valid_next           = 1'b1;
                result_next.channel  = op.channel;
                result_next.chip     = op.channel[eisp_pkg::CHAN_W-1:eisp_pkg::PIN_IDX_W];
                result_next.pk_pk    = eisp_pkg::CODE_W'(max_next - min_next);
                if (op.last_chan)
                begin
                    result_next.next_chip     = '0;
                    result_next.next_pin_mask = '0;
                    result_next.sweep_done    = 1'b1;
                end
                else
                begin
                    result_next.next_chip     = nxt[eisp_pkg::CHAN_W-1:eisp_pkg::PIN_IDX_W];
                    result_next.next_pin_mask =
                        eisp_pkg::PIN_W'(1) << nxt[eisp_pkg::PIN_IDX_W-1:0];
                    result_next.sweep_done    = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        max_reg    <= max_next;
        min_reg    <= min_next;
        result_reg <= result_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign result_valid = valid_reg;
    assign result       = result_reg;

endmodule

FILE: sim/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import eisp_pkg::*;

    // run limits and pacing
    localparam int CYCLE_LIMIT  = 500000;
    localparam int ITEM_TARGET  = 650;
    localparam int LONG_HOLD    = 100;   // receiver hold-off that backs up the pipe
    localparam int QUIET_CYCLES = 8;     // covers front stage, queue and back stage

    localparam logic signed [CODE_W-1:0] CODE_MAX = {1'b0, {(CODE_W-1){1'b1}}};
    localparam logic signed [CODE_W-1:0] CODE_MIN = {1'b1, {(CODE_W-1){1'b0}}};

    // clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always #2 clk = ~clk;

    // block ports
    logic                   sample_valid = 1'b0;
    logic                   sample_stall;
    sample_t                sample       = '0;
    logic                   result_valid;
    logic                   result_stall = 1'b0;
    result_t                result;
    logic                   cfg_we       = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index    = '0;
    logic [CFG_DATA_W-1:0]  cfg_data     = '0;

    electrode_impedance_sweep_pkpk_core DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // stimulus side
    sample_t samples_to_send[$];
    int      samples_queued = 0;
    bit      calm           = 1'b0;   // set for the last stretch: no idling anywhere
    bit      hold_req       = 1'b0;   // asks the receiver for its long hold-off
    bit      beat_taken     = 1'b0;   // sample beat accepted at the last rising edge
    int      gap_left       = 0;

    // receiver side
    bit hold_served = 1'b0;
    int hold_left   = 0;
    int stall_left  = 0;

    // expected channel reports and error count
    result_t channel_reports_due[$];
    int      bad_reports = 0;
    int      cycle_cnt   = 0;

    // sweep tracker: our own copy of registers and channel state
    logic [SETTLE_W-1:0]      settle_cfg = SETTLE_RESET;
    logic [WINDOW_W-1:0]      window_cfg = WINDOW_RESET;
    logic [CHAN_W-1:0]        cur_chan   = '0;
    logic [SETTLE_W-1:0]      settle_cnt = '0;
    logic [WINDOW_W-1:0]      kept_cnt   = '0;
    logic signed [CODE_W-1:0] hi_code    = '0;
    logic signed [CODE_W-1:0] lo_code    = '0;
    bit                       sweep_parked = 1'b0;

    function automatic void sweep_clear();
        cur_chan     = '0;
        settle_cnt   = '0;
        kept_cnt     = '0;
        hi_code      = '0;
        lo_code      = '0;
        sweep_parked = 1'b0;
    endfunction

    // advance the sweep by one sample beat; returns 1 when a channel closes
    function automatic bit sweep_advance(input sample_t s, output result_t r);
        int win;
        int nxt;
        r = '0;
        if (s.restart)
        begin
            sweep_clear();
            return 1'b0;
        end
        // after the last channel everything is ignored until restart
        if (sweep_parked)
            return 1'b0;
        // settling: a lowered setting ends this as soon as the count reaches it
        if (settle_cnt < settle_cfg)
        begin
            settle_cnt = settle_cnt + 1'b1;
            return 1'b0;
        end
        if (kept_cnt == 0)
        begin
            hi_code = s.raw_code;
            lo_code = s.raw_code;
        end
        else
        begin
            if (s.raw_code > hi_code)
                hi_code = s.raw_code;
            if (s.raw_code < lo_code)
                lo_code = s.raw_code;
        end
        kept_cnt = kept_cnt + 1'b1;
        // window of zero acts as one, above the maximum is clipped
        win = int'(window_cfg);
        if (win == 0)
            win = 1;
        if (win > MAX_WINDOW)
            win = MAX_WINDOW;
        if (int'(kept_cnt) < win)
            return 1'b0;
        r.channel = cur_chan;
        r.chip    = CHIP_W'(int'(cur_chan) / CHANNELS_PER_CHIP);
        r.pk_pk   = hi_code - lo_code;
        if (int'(cur_chan) == CHANNEL_COUNT_DEF - 1)
        begin
            // last channel: lead-off current off, sweep parks
            r.next_chip     = '0;
            r.next_pin_mask = '0;
            r.sweep_done    = 1'b1;
            sweep_parked    = 1'b1;
            cur_chan        = '0;
        end
        else
        begin
            nxt             = int'(cur_chan) + 1;
            r.next_chip     = CHIP_W'(nxt / CHANNELS_PER_CHIP);
            r.next_pin_mask = PIN_W'(1 << (nxt % CHANNELS_PER_CHIP));
            r.sweep_done    = 1'b0;
            cur_chan        = CHAN_W'(nxt);
        end
        settle_cnt = '0;
        kept_cnt   = '0;
        hi_code    = '0;
        lo_code    = '0;
        return 1'b1;
    endfunction

    function automatic void match_field(input string name, input logic [CODE_W-1:0] want,
                                        input logic [CODE_W-1:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            bad_reports++;
        end
    endfunction

    // sample driver: changes on the falling edge, holds a stalled beat untouched
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (sample_valid && !beat_taken)
            begin
                // beat still waiting: leave valid and payload alone
            end
            else if (gap_left > 0)
            begin
                sample_valid <= 1'b0;
                gap_left     <= gap_left - 1;
            end
            else if (samples_to_send.size() != 0 && !calm && $urandom_range(0, 9) == 0)
            begin
                // idle burst with sample_valid low
                sample_valid <= 1'b0;
                gap_left     <= $urandom_range(0, 16);
            end
            else if (samples_to_send.size() != 0)
            begin
                sample_valid <= 1'b1;
                sample       <= samples_to_send.pop_front();
            end
            else
            begin
                sample_valid <= 1'b0;
            end
        end
    end

    // result receiver: random stall bursts plus one long hold-off on request
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_req && !hold_served)
            begin
                result_stall <= 1'b1;
                hold_left    <= LONG_HOLD;
                hold_served  <= 1'b1;
            end
            else if (hold_left > 0)
            begin
                result_stall <= 1'b1;
                hold_left    <= hold_left - 1;
            end
            else if (stall_left > 0)
            begin
                result_stall <= 1'b1;
                stall_left   <= stall_left - 1;
            end
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                result_stall <= 1'b1;
                stall_left   <= $urandom_range(0, 16);
            end
            else
            begin
                result_stall <= 1'b0;
            end
        end
    end

    // monitor: register writes, accepted sample beats, accepted result beats
    always @(posedge clk)
    begin
        result_t got_report;
        result_t want;
        beat_taken <= rst_n && sample_valid && !sample_stall;
        if (rst_n)
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_SETTLE_COUNT:  settle_cfg = cfg_data[SETTLE_W-1:0];
                    REG_WINDOW_LENGTH: window_cfg = cfg_data[WINDOW_W-1:0];
                    default: ;
                endcase
            end
            if (sample_valid && !sample_stall)
            begin
                if (sweep_advance(sample, got_report))
                    channel_reports_due.push_back(got_report);
            end
            if (result_valid && !result_stall)
            begin
                if (channel_reports_due.size() == 0)
                begin
                    $error("result beat with nothing expected: channel %0d pk_pk 0x%0h",
                           result.channel, result.pk_pk);
                    bad_reports++;
                end
                else
                begin
                    want = channel_reports_due.pop_front();
                    match_field("channel", want.channel, result.channel);
                    match_field("chip", want.chip, result.chip);
                    match_field("pk_pk", want.pk_pk, result.pk_pk);
                    match_field("next_chip", want.next_chip, result.next_chip);
                    match_field("next_pin_mask", want.next_pin_mask, result.next_pin_mask);
                    match_field("sweep_done", want.sweep_done, result.sweep_done);
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // mostly full-range codes, with the rails and values near zero mixed in
    function automatic logic signed [CODE_W-1:0] pick_code();
        int v;
        case ($urandom_range(0, 9))
            0: return CODE_MAX;
            1: return CODE_MIN;
            2:
            begin
                v = int'($urandom_range(0, 64)) - 32;
                return CODE_W'(v);
            end
            default: return CODE_W'($urandom());
        endcase
    endfunction

    task automatic queue_sample(input bit rs, input logic signed [CODE_W-1:0] code);
        sample_t s;
        s.raw_code = code;
        s.restart  = rs;
        samples_to_send.push_back(s);
        samples_queued++;
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(val);
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // wait until every beat is in and every report is out for a run of quiet cycles
    task automatic wait_quiet();
        int quiet;
        quiet = 0;
        while (quiet < QUIET_CYCLES)
        begin
            @(negedge clk);
            if (samples_to_send.size() != 0 || sample_valid ||
                channel_reports_due.size() != 0)
                quiet = 0;
            else
                quiet++;
        end
    endtask

    // one sweep: set both registers, restart, then enough beats for n_chan channels
    task automatic play_sweep(input int settle, input int window, input int n_chan,
                              input int tail);
        int eff;
        int n;
        write_reg(REG_SETTLE_COUNT, settle);
        write_reg(REG_WINDOW_LENGTH, window);
        eff = (window == 0) ? 1 : ((window > MAX_WINDOW) ? MAX_WINDOW : window);
        n   = n_chan * (settle + eff);
        queue_sample(1'b1, pick_code());
        for (int i = 0; i < n; i++)
            queue_sample($urandom_range(0, 149) == 0, pick_code());
        // extra beats land on a parked sweep when the sweep completed
        for (int i = 0; i < tail; i++)
            queue_sample(1'b0, pick_code());
        wait_quiet();
    endtask

    initial
    begin
        int settle;
        int window;
        int eff;
        int n_chan;
        int phase;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: settle 10, window 32, two channels without restart
        for (int i = 0; i < 2 * (10 + MAX_WINDOW); i++)
            queue_sample(1'b0, pick_code());
        wait_quiet();

        // directed: full-scale spans, zero span, restart inside a window
        write_reg(REG_SETTLE_COUNT, 0);
        write_reg(REG_WINDOW_LENGTH, 2);
        queue_sample(1'b1, '0);
        queue_sample(1'b0, CODE_MAX);
        queue_sample(1'b0, CODE_MIN);
        queue_sample(1'b0, CODE_MIN);
        queue_sample(1'b0, CODE_MAX);
        queue_sample(1'b0, '0);
        queue_sample(1'b0, CODE_W'(-1));
        queue_sample(1'b0, CODE_W'(123));
        queue_sample(1'b1, CODE_MAX);
        queue_sample(1'b0, CODE_W'(-1));
        queue_sample(1'b0, CODE_W'(-1));
        wait_quiet();

        // settle count lowered while the sweep is still settling
        write_reg(REG_SETTLE_COUNT, 15);
        queue_sample(1'b1, CODE_MIN);
        for (int i = 0; i < 5; i++)
            queue_sample(1'b0, pick_code());
        wait_quiet();
        write_reg(REG_SETTLE_COUNT, 2);
        queue_sample(1'b0, CODE_MAX);
        queue_sample(1'b0, CODE_W'(1));
        wait_quiet();

        // random sweeps: extremes first, then mostly short settle and window
        phase = 0;
        while (samples_queued < ITEM_TARGET)
        begin
            if (phase == 0)
            begin
                // one report per beat while the receiver holds off: pipe fills up
                hold_req <= 1'b1;
                play_sweep(0, 1, 32, 8);
            end
            else if (phase == 1)
                play_sweep(15, 63, 2, 0);
            else if (phase == 2)
                play_sweep(15, 0, 3, 0);
            else if (phase == 3)
                play_sweep(0, 33, 2, 0);
            else
            begin
                settle = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 15)
                                                     : $urandom_range(0, 3);
                window = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 63)
                                                     : $urandom_range(0, 4);
                eff    = (window == 0) ? 1 : ((window > MAX_WINDOW) ? MAX_WINDOW : window);
                // long channels get only a few of them
                n_chan = (settle + eff > 8) ? $urandom_range(1, 3) : CHANNEL_COUNT_DEF;
                play_sweep(settle, window, n_chan, $urandom_range(0, 6));
            end
            phase++;
        end

        // last stretch at full rate on both sides
        calm <= 1'b1;
        play_sweep(1, 2, CHANNEL_COUNT_DEF, 4);

        if (bad_reports == 0 && channel_reports_due.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
